// ===== hw/rtl/sdet_pkg.sv =====
// Shared types and constants for the sorted date event table.
// No dependencies; imported by sdet_table and sorted_date_event_table_top.
package sdet_pkg;

  // table geometry
  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // request opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // result status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_MATCH    = 2'd2;
  localparam logic [1:0] ST_NOMATCH  = 2'd3;

  // packed date orders by year, then month, then day
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  typedef struct packed {
    date_t       date;
    logic [15:0] tag;
  } entry_t;

  // table write port
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

endpackage

// ===== hw/rtl/sdet_table.sv =====
// Entry storage of the sorted date event table: one write, one registered read.
// Depends on sdet_pkg.
module sdet_table
  import sdet_pkg::*;
(
  input  logic             clk,
  input  tbl_wr_t          wr,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [ENTRIES];
  entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/sorted_date_event_table_top.sv =====
// Top level of the sorted date event table: request control and result register.
// Depends on sdet_pkg and sdet_table.
//
// Keeps up to 64 dated entries sorted by date in a single-port-read table. An insert
// moves up one place every stored entry with a later date, then writes the new entry;
// a full table answers without moving anything. A lookup streams through all stored
// entries at one per cycle while the result side does not stall; the one read port
// of the table sets this pace. A new request is taken once the previous one has put
// its last result into the output register, even while that result still waits to
// be taken.
module sorted_date_event_table_top
  import sdet_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [13:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic [15:0] in_tag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [5:0]  out_position,
  output logic [15:0] out_tag_out,
  output logic        out_last
);

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_INS_CMP   = 5'b00010,
    S_INS_PLACE = 5'b00100,
    S_LOOKUP    = 5'b01000,
    S_EMIT      = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  entry_t           key_r, key_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             cmp_v_r, cmp_v_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [1:0]       res_status_r, res_status_nxt;
  logic [5:0]       res_pos_r, res_pos_nxt;
  logic [15:0]      res_tag_r, res_tag_nxt;

  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [5:0]       out_pos_r;
  logic [15:0]      out_tag_r;
  logic             out_last_r;

  tbl_wr_t          wr;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;

  logic             accept;
  logic             out_free;
  logic             load_out;
  logic             load_last;
  logic             later;
  logic             match;
  logic             stall;
  logic             scan_more;
  logic             full;

  sdet_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign full      = (count_r == CNT_W'(ENTRIES));
  assign later     = (rd_data.date > key_r.date);
  assign match     = cmp_v_r && (rd_data.date == key_r.date);
  assign stall     = match && pend_v_r && !out_free;
  assign scan_more = (scan_r < count_r);

  // request sequencing
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    key_nxt        = key_r;
    cur_nxt        = cur_r;
    scan_nxt       = scan_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_v_nxt      = cmp_v_r;
    pend_v_nxt     = pend_v_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    res_tag_nxt    = res_tag_r;
    wr             = '0;
    rd_addr        = '0;
    load_out       = 1'b0;
    load_last      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        rd_addr = IDX_W'(count_r - CNT_W'(1));
        if (accept) begin
          key_nxt.date  = '{year: in_year, month: in_month, day: in_day};
          key_nxt.tag   = in_tag;
          res_tag_nxt   = '0;
          res_pos_nxt   = '0;
          pend_v_nxt    = 1'b0;
          if (in_op == OP_LOOKUP) begin
            scan_nxt  = '0;
            cmp_v_nxt = 1'b0;
            state_nxt = S_LOOKUP;
          end else if (full) begin
            res_status_nxt = ST_FULL;
            state_nxt      = S_EMIT;
          end else begin
            cur_nxt   = count_r[IDX_W-1:0];
            state_nxt = (count_r == '0) ? S_INS_PLACE : S_INS_CMP;
          end
        end
      end

      // rd_data holds the entry just below cur_r
      S_INS_CMP: begin
        wr.en   = 1'b1;
        wr.addr = cur_r;
        rd_addr = cur_r - IDX_W'(2);
        if (later) begin
          wr.data   = rd_data;
          cur_nxt   = cur_r - IDX_W'(1);
          state_nxt = (cur_r == IDX_W'(1)) ? S_INS_PLACE : S_INS_CMP;
        end else begin
          wr.data        = key_r;
          count_nxt      = count_r + CNT_W'(1);
          res_status_nxt = ST_INSERTED;
          res_pos_nxt    = 6'(cur_r);
          state_nxt      = S_EMIT;
        end
      end

      S_INS_PLACE: begin
        wr.en          = 1'b1;
        wr.addr        = cur_r;
        wr.data        = key_r;
        count_nxt      = count_r + CNT_W'(1);
        res_status_nxt = ST_INSERTED;
        res_pos_nxt    = 6'(cur_r);
        state_nxt      = S_EMIT;
      end

      // streamed scan; held match waits until a later one shows it is not last
      S_LOOKUP: begin
        rd_addr = stall ? cmp_idx_r : scan_r[IDX_W-1:0];
        if (match && pend_v_r && out_free) begin
          load_out = 1'b1;
        end
        if (match && !stall) begin
          res_status_nxt = ST_MATCH;
          res_pos_nxt    = 6'(cmp_idx_r);
          res_tag_nxt    = rd_data.tag;
          pend_v_nxt     = 1'b1;
        end
        if (!stall) begin
          if (scan_more) begin
            cmp_v_nxt   = 1'b1;
            cmp_idx_nxt = scan_r[IDX_W-1:0];
            scan_nxt    = scan_r + CNT_W'(1);
          end else begin
            cmp_v_nxt = 1'b0;
          end
        end
        if (!cmp_v_r && !scan_more) begin
          if (!pend_v_r) begin
            res_status_nxt = ST_NOMATCH;
            res_pos_nxt    = '0;
            res_tag_nxt    = '0;
          end
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          load_out   = 1'b1;
          load_last  = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cmp_v_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      cmp_v_r  <= cmp_v_nxt;
      pend_v_r <= pend_v_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    cur_r        <= cur_nxt;
    scan_r       <= scan_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    res_tag_r    <= res_tag_nxt;
    if (load_out) begin
      out_status_r <= res_status_r;
      out_pos_r    <= res_pos_r;
      out_tag_r    <= res_tag_r;
      out_last_r   <= load_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_pos_r;
  assign out_tag_out  = out_tag_r;
  assign out_last     = out_last_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("entry count above table depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("entry count moved by other than one");

  a_ins_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_CMP) |-> (cur_r != '0 && CNT_W'(cur_r) <= count_r))
    else $error("insert cursor out of range");

  a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOKUP && cmp_v_r) |-> (CNT_W'(cmp_idx_r) < count_r))
    else $error("lookup compares an entry beyond the count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !load_out)
    else $error("result register overwritten while held");
`endif

endmodule
